FILE: hw/rtl/bss_pkg.sv
`timescale 1ns / 1ps

package bss_pkg;

  // Item modes on the input channel.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_HAY    = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  localparam int unsigned OFFSET_W = 32;
  localparam logic [OFFSET_W-1:0] POS_MAX = '1;

  // Shift requests from the control path to the compare array.
  typedef struct packed {
    logic       pat_push;
    logic       win_push;
    logic [7:0] data;
  } shift_t;

endpackage

FILE: hw/rtl/bss_in_if.sv
`timescale 1ns / 1ps

interface bss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

FILE: hw/rtl/bss_out_if.sv
`timescale 1ns / 1ps

interface bss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] match_offset;

  modport source (output valid, output status, output match_offset, input ready);
  modport sink   (input valid, input status, input match_offset, output ready);
endinterface

FILE: hw/rtl/bss_match.sv
`timescale 1ns / 1ps

// Pattern and window shift lines with a parallel compare. The pattern is held
// aligned to the window: entry k is the byte expected k bytes before the
// newest haystack byte, so every compare sits at a fixed position.
module bss_match #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                clk,
  input  bss_pkg::shift_t     shift,
  input  logic [LEN_W-1:0]    len,
  output logic                hit
);

  localparam int unsigned WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [7:0] pat_r [MAX_PATTERN];
  logic [7:0] win_r [WIN_D];
  logic [7:0] cur   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok;

  always_ff @(posedge clk) begin
    if (shift.pat_push) begin
      pat_r[0] <= shift.data;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        pat_r[k] <= pat_r[k-1];
      end
    end
    if (shift.win_push) begin
      win_r[0] <= shift.data;
      for (int k = 1; k < WIN_D; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end
  end

  // Window as it stands once the incoming byte is in, compared lane by lane.
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k == 0) begin
        cur[k] = shift.data;
      end else begin
        cur[k] = win_r[(k > 0) ? k - 1 : 0];
      end
      ok[k] = (LEN_W'(k) >= len) || (pat_r[k] == cur[k]);
    end
  end

  assign hit = &ok;

endmodule

FILE: hw/rtl/bss_ctrl.sv
`timescale 1ns / 1ps

// Input stage, search state and result register.
module bss_ctrl #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_mode,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [bss_pkg::OFFSET_W-1:0]    out_match_offset,
  input  logic                            hit,
  output bss_pkg::shift_t                 shift,
  output logic [LEN_W-1:0]                len,
  output logic                            ovf,
  output logic                            advance
);

  logic                          stg_valid_r;
  logic [1:0]                    mode_r;
  logic [7:0]                    byte_r;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [bss_pkg::OFFSET_W-1:0]  pos_r, pos_nxt, pos_inc;
  logic                          rep_r, rep_nxt;
  logic                          emit;
  logic [1:0]                    status_nxt;
  logic [bss_pkg::OFFSET_W-1:0]  offset_nxt;
  logic                          out_valid_r;
  logic [1:0]                    out_status_r;
  logic [bss_pkg::OFFSET_W-1:0]  out_offset_r;
  logic                          room;

  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;
  assign room     = len_r < LEN_W'(MAX_PATTERN);
  assign pos_inc  = (pos_r == bss_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;

  always_comb begin
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    pos_nxt    = pos_r;
    rep_nxt    = rep_r;
    emit       = 1'b0;
    status_nxt = bss_pkg::ST_FOUND;
    offset_nxt = '0;
    shift.pat_push = 1'b0;
    shift.win_push = 1'b0;
    shift.data     = byte_r;
    if (advance) begin
      case (bss_pkg::mode_t'(mode_r))
        bss_pkg::MODE_CLEAR: begin
          len_nxt = '0;
          ovf_nxt = 1'b0;
          pos_nxt = '0;
          rep_nxt = 1'b0;
        end
        bss_pkg::MODE_APPEND: begin
          pos_nxt = '0;
          rep_nxt = 1'b0;
          if (room) begin
            shift.pat_push = 1'b1;
            len_nxt        = len_r + 1'b1;
          end else begin
            ovf_nxt    = 1'b1;
            emit       = 1'b1;
            status_nxt = bss_pkg::ST_TOO_LONG;
          end
        end
        bss_pkg::MODE_HAY: begin
          pos_nxt        = pos_inc;
          shift.win_push = 1'b1;
          if (!rep_r && !ovf_r) begin
            if (len_r == '0) begin
              rep_nxt = 1'b1;
              emit    = 1'b1;
            end else if ((pos_inc >= bss_pkg::OFFSET_W'(len_r)) && hit) begin
              rep_nxt    = 1'b1;
              emit       = 1'b1;
              offset_nxt = pos_inc - bss_pkg::OFFSET_W'(len_r);
            end
          end
        end
        default: begin
          // End of haystack: report unless a match already went out.
          if (!rep_r) begin
            emit = 1'b1;
            if (ovf_r) begin
              status_nxt = bss_pkg::ST_TOO_LONG;
            end else if (len_r != '0) begin
              status_nxt = bss_pkg::ST_NOT_FOUND;
            end
          end
          pos_nxt = '0;
          rep_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      pos_r <= pos_nxt;
      rep_r <= rep_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mode_r <= in_mode;
      byte_r <= in_data_byte;
    end
    if (emit) begin
      out_status_r <= status_nxt;
      out_offset_r <= offset_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_offset = out_offset_r;
  assign len              = len_r;
  assign ovf              = ovf_r;

endmodule

FILE: hw/rtl/byte_substring_search_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Payload                              Handshake
// in_ch    sink       mode[1:0], data_byte[7:0]            valid / ready
// out_ch   source     status[1:0], match_offset[31:0]      valid / ready
//
// One transaction per cycle is sustained on the input while no held result
// blocks it; a result is written to the output register from the input stage.
// Each item passes an input register, one parallel compare of the window
// against the aligned pattern, and the result register.
// Reset (rst_n, synchronous, active low) clears the control state; the
// pattern and window shift lines hold data only and are not reset.
// A held result stalls the input stage only while out_ch.ready is low.
module byte_substring_search_core #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  bss_in_if.sink         in_ch,
  bss_out_if.source      out_ch
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

  bss_pkg::shift_t   shift;
  logic [LEN_W-1:0]  len;
  logic              ovf;
  logic              hit;
  logic              advance;

  // Control: the input stage, pattern length, overflow flag, saturating
  // haystack position and the result register live here.
  bss_ctrl #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_mode          (in_ch.mode),
    .in_data_byte     (in_ch.data_byte),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_match_offset (out_ch.match_offset),
    .hit              (hit),
    .shift            (shift),
    .len              (len),
    .ovf              (ovf),
    .advance          (advance)
  );

  // Compare array: pattern bytes are shifted in so that each lane lines up
  // with the window byte it must equal; lanes at or above the pattern length
  // always pass.
  bss_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_match (
    .clk   (clk),
    .shift (shift),
    .len   (len),
    .hit   (hit)
  );

  // The stored length never exceeds the pattern bound.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len <= LEN_W'(MAX_PATTERN))
    else $error("pattern length above bound");

  // A too-long result can only be shown while the overflow flag is set.
  a_too_long_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == bss_pkg::ST_TOO_LONG)) |-> ovf)
    else $error("too-long result without overflow");

  // A new result only follows a transaction leaving the input stage.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_ch.valid)) |-> $past(advance))
    else $error("result without a processed transaction");

  // Only a found result carries a nonzero offset.
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != bss_pkg::ST_FOUND)) |->
      (out_ch.match_offset == '0))
    else $error("offset on a result that is not a match");

endmodule

FILE: tb/search_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the substring search core, predicts the results
// that the accepted input transactions produce and compares them in order.
module search_checker #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic clk,
  input  logic rst_n,
  bss_in_if    in_ch,
  bss_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  import bss_pkg::*;

  typedef struct {
    status_t             status;
    logic [OFFSET_W-1:0] offset;
  } outcome_t;

  outcome_t due_outcomes[$];

  // Predicted search state.
  logic [7:0]          needle [MAX_PATTERN];
  logic [7:0]          recent [MAX_PATTERN];
  int unsigned         needle_len;
  logic                needle_overflow;
  logic [OFFSET_W-1:0] hay_pos;
  logic                match_seen;

  task automatic restart_search();
    int k;
    for (k = 0; k < MAX_PATTERN; k++) recent[k] = 8'h00;
    hay_pos    = '0;
    match_seen = 1'b0;
  endtask

  task automatic expect_outcome(input status_t st, input logic [OFFSET_W-1:0] ofs);
    outcome_t o;
    o.status = st;
    o.offset = ofs;
    due_outcomes.push_back(o);
  endtask

  task automatic predict_search(input mode_t m, input logic [7:0] b);
    int   k;
    logic hit;
    case (m)
      MODE_CLEAR: begin
        needle_len      = 0;
        needle_overflow = 1'b0;
        restart_search();
      end
      MODE_APPEND: begin
        restart_search();
        if (needle_len < MAX_PATTERN) begin
          needle[needle_len] = b;
          needle_len++;
        end else begin
          needle_overflow = 1'b1;
          expect_outcome(ST_TOO_LONG, '0);
        end
      end
      MODE_HAY: begin
        if (hay_pos != POS_MAX) hay_pos++;
        for (k = MAX_PATTERN - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = b;
        if (!match_seen && !needle_overflow) begin
          if (needle_len == 0) begin
            match_seen = 1'b1;
            expect_outcome(ST_FOUND, '0);
          end else if (hay_pos >= needle_len) begin
            hit = 1'b1;
            for (k = 0; k < needle_len; k++) begin
              if (needle[k] !== recent[needle_len-1-k]) hit = 1'b0;
            end
            if (hit) begin
              match_seen = 1'b1;
              expect_outcome(ST_FOUND, hay_pos - needle_len);
            end
          end
        end
      end
      default: begin
        if (!match_seen) begin
          if (needle_overflow) expect_outcome(ST_TOO_LONG, '0);
          else if (needle_len == 0) expect_outcome(ST_FOUND, '0);
          else expect_outcome(ST_NOT_FOUND, '0);
        end
        restart_search();
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      due_outcomes.delete();
      needle_len      = 0;
      needle_overflow = 1'b0;
      restart_search();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_search(mode_t'(in_ch.mode), in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (due_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d offset 0x%08h",
                                    out_ch.status, out_ch.match_offset));
        end else begin
          want = due_outcomes.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_ch.status, want.status));
          if (out_ch.match_offset !== want.offset)
            report_mismatch($sformatf("match_offset 0x%08h, expected 0x%08h",
                                      out_ch.match_offset, want.offset));
        end
      end
    end
    pending = due_outcomes.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

// Top of the regression for the substring search core. This module only
// makes stimulus, paces both channels and gives the verdict; all prediction
// and comparison lives in the checker instance next to the block.
module testbench;
  import bss_pkg::*;

  localparam int unsigned MAX_PATTERN = 16;
  // Input transactions to drive before the run winds down.
  localparam int ITEM_TARGET = 1900;
  // Cycles without any transaction on either channel before the run is
  // declared hung. The slowest legal case is a receiver stall on top of a
  // sender gap, so this is far beyond it.
  localparam int QUIET_LIMIT = 2000;

  logic clk;
  logic rst_n;

  bss_in_if  in_ch ();
  bss_out_if out_ch ();

  int fail_count;
  int pending;
  int checked;
  int items_sent   = 0;
  int sequences    = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;

  byte_substring_search_core #(
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  search_checker #(
    .MAX_PATTERN(MAX_PATTERN)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The watchdog restarts its count on every transaction on either channel.
  // A block that drops a result leaves the checker waiting forever, so the
  // drain at the end of the run is also covered by this limit.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("byte_substring_search_core regression: fail");
      $finish;
    end
  end

  // The receiver changes its behavior at random intervals: always
  // ready, coin-flip ready, mostly ready with occasional long stalls, or a
  // fixed one-in-four stall. Stalls therefore land on every phase of the
  // sender's bursts.
  initial begin
    int phase_cycle = 0;
    int style       = 0;
    int stall_left  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_cycle == 0) begin
        style       = $urandom_range(0, 3);
        phase_cycle = $urandom_range(50, 400);
      end
      phase_cycle--;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        case (style)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = 1'($urandom_range(0, 1));
          2: begin
            if ($urandom_range(0, 15) == 0) begin
              stall_left   = $urandom_range(5, 20);
              out_ch.ready = 1'b0;
            end else begin
              out_ch.ready = 1'b1;
            end
          end
          default: out_ch.ready = (phase_cycle % 4) != 0;
        endcase
      end
    end
  end

  // Drives one input transaction and returns once the block has taken it.
  // The sender works in bursts: at the start of each burst it may sit idle
  // for a random number of cycles with junk on the payload lines. Within a
  // burst valid simply stays high from one transaction to the next.
  task automatic send_item(input mode_t m, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid     = 1'b0;
        in_ch.mode      = 2'($urandom_range(0, 3));
        in_ch.data_byte = 8'($urandom_range(0, 255));
      end
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.mode      = m;
    in_ch.data_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Holds the input channel idle until every predicted result has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Haystack and pattern bytes come either from the whole byte range or
  // from a four-symbol alphabet around a random base; the narrow alphabet
  // makes partial and accidental matches common.
  function automatic logic [7:0] pick_byte(input bit wide, input logic [7:0] base);
    if (wide) return 8'($urandom_range(0, 255));
    return base ^ 8'($urandom_range(0, 3));
  endfunction

  // One search: usually clear the pattern, load it, stream a haystack and
  // end it. Most patterns are short so that matches happen often; a few
  // fill the store and a few run past it to hit the overflow path. The
  // pattern is planted into most haystacks, and now and then a random
  // transaction is thrown into the middle to break the sequence.
  task automatic gen_sequence();
    logic [7:0] pat_bytes [MAX_PATTERN + 2];
    logic [7:0] base;
    logic [7:0] b;
    bit         wide;
    int         plen;
    int         hlen;
    int         plant_at;
    int         roll;
    int         k;
    wide = ($urandom_range(0, 3) == 0);
    base = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 8) plen = 0;
    else if (roll < 78) plen = $urandom_range(1, 4);
    else if (roll < 93) plen = $urandom_range(5, MAX_PATTERN);
    else plen = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 2);

    if ($urandom_range(0, 6) != 0) send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
    for (k = 0; k < plen; k++) begin
      pat_bytes[k] = pick_byte(wide, base);
      send_item(MODE_APPEND, pat_bytes[k]);
    end

    hlen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 150) : $urandom_range(0, 30);
    plant_at = -1;
    if (plen <= MAX_PATTERN && plen <= hlen && $urandom_range(0, 9) < 6) begin
      plant_at = $urandom_range(0, hlen - plen);
    end
    for (k = 0; k < hlen; k++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_item(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      if (plant_at >= 0 && k >= plant_at && k < plant_at + plen) begin
        b = pat_bytes[k - plant_at];
      end else begin
        b = pick_byte(wide, base);
      end
      send_item(MODE_HAY, b);
    end
    if ($urandom_range(0, 9) != 0) send_item(MODE_END, 8'($urandom_range(0, 255)));
    sequences++;
  endtask

  initial begin
    int  k;
    bit  pressure_done;
    pressure_done   = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_CLEAR;
    in_ch.data_byte = 8'h00;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed part. An empty pattern ending a haystack with no bytes
    // counts as found at offset zero.
    send_item(MODE_END, 8'hFF);
    // An empty pattern is found on the first haystack byte; the second
    // byte and the end of haystack must then stay silent.
    send_item(MODE_HAY, 8'h00);
    send_item(MODE_HAY, 8'hFF);
    send_item(MODE_END, 8'h00);
    // Fill the store to its bound with bytes spanning the whole range,
    // then push one more to overflow it. A haystack byte after an
    // overflow finds nothing and the end reports the overflow again.
    send_item(MODE_CLEAR, 8'hFF);
    for (k = 0; k < MAX_PATTERN; k++) send_item(MODE_APPEND, 8'(k * 17));
    send_item(MODE_APPEND, 8'hAA);
    send_item(MODE_HAY, 8'h00);
    send_item(MODE_END, 8'hFF);
    // Let everything settle once with the input idle.
    drain_results();

    // Random part: mostly well-formed searches, some loose noise, and one
    // pause halfway through that waits out every pending result.
    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent >= ITEM_TARGET / 2) begin
        drain_results();
        pressure_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end else begin
        gen_sequence();
      end
    end

    // Wait for the last results, then keep the clock running so that any
    // result that should not be there still shows up.
    drain_results();
    repeat (10) @(posedge clk);

    $display("Drove %0d input transactions, with %0d generated searches among loose noise,",
             items_sent, sequences);
    $display("and compared %0d results covering matches, misses, empty and overflowed patterns.",
             checked);
    if (fail_count == 0) begin
      $display("byte_substring_search_core regression: pass");
    end else begin
      $display("byte_substring_search_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bss_pkg.sv
hw/rtl/bss_in_if.sv
hw/rtl/bss_out_if.sv
hw/rtl/bss_match.sv
hw/rtl/bss_ctrl.sv
hw/rtl/byte_substring_search_core.sv
tb/search_checker.sv
tb/testbench.sv
